>>> hw/rtl/accel_minmax_calibrate_rescale_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer calibrator
// Shared helpers so that every checked module writes its properties alike.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MINMAX_CALIBRATE_RESCALE_DEFINES_SVH
`define ACCEL_MINMAX_CALIBRATE_RESCALE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define AMCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define AMCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/amcr_pkg.sv
// ----------------------------------------------------------------------------
// amcr_pkg
// Types, codes and constants shared by the calibrator controller and datapath.
// ----------------------------------------------------------------------------
package amcr_pkg;

  localparam int SAMPLE_W  = 13;
  localparam int LEVEL_W   = 7;
  localparam int SPAN_W    = 14;
  localparam int PROD_W    = 20;
  localparam int DIV_STEPS = 7;
  localparam int AXES      = 3;

  localparam logic [SAMPLE_W-1:0] LIMIT_LOW_RST  = -13'sd4000;
  localparam logic [SAMPLE_W-1:0] LIMIT_HIGH_RST = 13'd4000;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX      = 7'd127;
  localparam logic [LEVEL_W-1:0]  LEVEL_MIN      = 7'd0;

  // Opcodes carried on the input tuser.
  localparam logic [1:0] OP_CLEAR     = 2'd0;
  localparam logic [1:0] OP_CALIBRATE = 2'd1;
  localparam logic [1:0] OP_MEASURE   = 2'd2;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef logic [2:0] step_t;
  localparam step_t LAST_STEP = 3'(DIV_STEPS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  clear;
    logic  calib;
    logic  prep;
    logic  mul;
    logic  div_step;
    logic  store;
    logic  load_out;
    axis_t axis;
  } amcr_cmd_t;

endpackage

>>> hw/rtl/amcr_ctrl.sv
// ----------------------------------------------------------------------------
// amcr_ctrl
// Sequencer: takes input words, steps the shared divider over three axes and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`include "accel_minmax_calibrate_rescale_defines.svh"

module amcr_ctrl
  import amcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_opcode,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output amcr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  axis_t  axis_r, axis_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Next-state and command decode.
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.axis      = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cmd.clear   = (in_opcode == OP_CLEAR);
          cmd.calib   = (in_opcode == OP_CALIBRATE);
          if (in_opcode == OP_MEASURE) begin
            state_nxt = ST_PREP;
            axis_nxt  = AXIS_X;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = ST_EMIT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_PREP;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= AXIS_X;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `AMCR_ASSERT_NEXT(a_measure_starts, accept && (in_opcode == OP_MEASURE), (state_r == ST_PREP) && (axis_r == AXIS_X), "measure word did not start the X axis")
  `AMCR_ASSERT_NOW(a_div_step_bound, state_r == ST_DIV, step_r <= LAST_STEP, "divider ran past its last step")
  `AMCR_ASSERT_NOW(a_axis_bound, state_r != ST_IDLE, axis_r <= AXIS_Z, "axis counter out of range")
  `AMCR_ASSERT_NEXT(a_emit_sets_valid, (state_r == ST_EMIT) && out_free, out_valid_r && (state_r == ST_IDLE), "result not presented after emit")

endmodule

>>> hw/rtl/amcr_dp.sv
// ----------------------------------------------------------------------------
// amcr_dp
// Datapath: per-axis limits, sample hold, a shared multiply-by-127 step and a
// shared restoring divider, per-axis level hold and the output data register.
// ----------------------------------------------------------------------------
module amcr_dp
  import amcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  amcr_cmd_t           cmd,
  input  logic [SAMPLE_W-1:0] in_sample_x,
  input  logic [SAMPLE_W-1:0] in_sample_y,
  input  logic [SAMPLE_W-1:0] in_sample_z,
  output logic [LEVEL_W-1:0]  out_level_x,
  output logic [LEVEL_W-1:0]  out_level_y,
  output logic [LEVEL_W-1:0]  out_level_z
);

  logic signed [SAMPLE_W-1:0] low_r  [AXES];
  logic signed [SAMPLE_W-1:0] high_r [AXES];
  logic signed [SAMPLE_W-1:0] smp_r  [AXES];
  logic        [LEVEL_W-1:0]  lvl_r  [AXES];
  logic signed [SAMPLE_W-1:0] smp_in [AXES];

  logic        [SAMPLE_W-1:0] diff_r, span_r;
  logic                       zero_r, sat_r;
  logic        [PROD_W-1:0]   rem_r, dvs_r;
  logic        [LEVEL_W-1:0]  quo_r;
  logic        [LEVEL_W-1:0]  out_x_r, out_y_r, out_z_r;

  logic signed [SPAN_W-1:0]   diff, span;
  logic                       fits;

  assign smp_in[0] = in_sample_x;
  assign smp_in[1] = in_sample_y;
  assign smp_in[2] = in_sample_z;

  // Limits: cleared, widened by calibrate words, reset to the default range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        low_r[i]  <= LIMIT_LOW_RST;
        high_r[i] <= LIMIT_HIGH_RST;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < AXES; i++) begin
        low_r[i]  <= '0;
        high_r[i] <= '0;
      end
    end else if (cmd.calib) begin
      for (int i = 0; i < AXES; i++) begin
        if (smp_in[i] < low_r[i]) begin
          low_r[i] <= smp_in[i];
        end
        if (smp_in[i] > high_r[i]) begin
          high_r[i] <= smp_in[i];
        end
      end
    end
  end

  // Sample hold for the measure sequence.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < AXES; i++) begin
        smp_r[i] <= smp_in[i];
      end
    end
  end

  // Offset and span of the selected axis, both sign-extended by one bit.
  assign diff = SPAN_W'(smp_r[cmd.axis]) - SPAN_W'(low_r[cmd.axis]);
  assign span = SPAN_W'(high_r[cmd.axis]) - SPAN_W'(low_r[cmd.axis]);

  // The quotient saturates exactly when the offset reaches the span, and is
  // zero for an empty or inverted range or a sample at or below the minimum.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      diff_r <= diff[SAMPLE_W-1:0];
      span_r <= span[SAMPLE_W-1:0];
      zero_r <= (span <= 0) || (diff <= 0);
      sat_r  <= (diff >= span);
    end
  end

  // Restoring divider: offset*127 over span, seven quotient bits.
  assign fits = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r <= {diff_r, 7'd0} - {7'd0, diff_r};
      dvs_r <= {1'b0, span_r, 6'd0};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem_r <= rem_r - dvs_r;
      end
      dvs_r <= dvs_r >> 1;
      quo_r <= {quo_r[LEVEL_W-2:0], fits};
    end
  end

  // Clamped level of the finished axis.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (zero_r) begin
        lvl_r[cmd.axis] <= LEVEL_MIN;
      end else if (sat_r) begin
        lvl_r[cmd.axis] <= LEVEL_MAX;
      end else begin
        lvl_r[cmd.axis] <= quo_r;
      end
    end
  end

  // Output data register, loaded when the result word is presented.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_x_r <= lvl_r[0];
      out_y_r <= lvl_r[1];
      out_z_r <= lvl_r[2];
    end
  end

  assign out_level_x = out_x_r;
  assign out_level_y = out_y_r;
  assign out_level_z = out_z_r;

endmodule

>>> hw/rtl/accel_minmax_calibrate_rescale.sv
// ----------------------------------------------------------------------------
// accel_minmax_calibrate_rescale
// Three-axis accelerometer min/max calibrator with linear rescale to 0..127.
// ----------------------------------------------------------------------------
// A clear or calibrate word is accepted and gives no result; the block is
// ready again on the next cycle. A measure word occupies the block from its
// acceptance through offset and span, the multiply by 127, seven steps of
// the shared restoring divider, and the clamp for X, Y and Z in turn, then
// through the load of the output register. The next word is accepted while
// that result waits on the output; a new measure result is held back only if
// the previous one has still not been taken.
module accel_minmax_calibrate_rescale
  import amcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // sample_x[12:0], sample_y[25:13], sample_z[38:26]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // level_x[6:0], level_y[13:7], level_z[20:14]
);

  amcr_cmd_t cmd;
  logic [LEVEL_W-1:0] level_x, level_y, level_z;

  amcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  amcr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_sample_x (in_tdata[12:0]),
    .in_sample_y (in_tdata[25:13]),
    .in_sample_z (in_tdata[38:26]),
    .out_level_x (level_x),
    .out_level_y (level_y),
    .out_level_z (level_z)
  );

  // Result word packing, padded to whole bytes.
  assign out_tdata = {3'd0, level_z, level_y, level_x};

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: accelerometer calibrator testbench
// Runs clear, calibrate and measure words through the calibrator. A scoreboard
// keeps its own copy of the six axis limits, predicts the three levels of
// every accepted measure word and checks each result word in order. Both
// stream sides idle at random, and the output is held off once for long
// enough to stall the input.
// ----------------------------------------------------------------------------
module tb;
  import amcr_pkg::*;

  // Opcode that the calibrator ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] z;
    logic [LEVEL_W-1:0] y;
    logic [LEVEL_W-1:0] x;
  } levels_t;

  // Tracks the axis limits and the levels still owed by the calibrator.
  class calib_scoreboard;
    int      low_lim[AXES];
    int      high_lim[AXES];
    levels_t pending_levels[$];
    int      fail_count;

    function new();
      for (int a = 0; a < AXES; a++) begin
        low_lim[a]  = int'($signed(LIMIT_LOW_RST));
        high_lim[a] = int'($signed(LIMIT_HIGH_RST));
      end
      fail_count = 0;
    endfunction

    // Linear map of a sample onto 0..127; an empty or inverted range gives 0.
    function logic [LEVEL_W-1:0] rescale(int s, int lo, int hi);
      int q;
      if (hi <= lo) return LEVEL_MIN;
      q = (s - lo) * int'(LEVEL_MAX - LEVEL_MIN) / (hi - lo) + int'(LEVEL_MIN);
      if (q < int'(LEVEL_MIN)) return LEVEL_MIN;
      if (q > int'(LEVEL_MAX)) return LEVEL_MAX;
      return LEVEL_W'(q);
    endfunction

    // Applies one accepted input word to the limits or queues its result.
    function void note_word(logic [1:0] op, sample_t sx, sample_t sy, sample_t sz);
      int      s[AXES];
      levels_t lv;
      s[0] = int'(sx);
      s[1] = int'(sy);
      s[2] = int'(sz);
      case (op)
        OP_CLEAR: begin
          for (int a = 0; a < AXES; a++) begin
            low_lim[a]  = 0;
            high_lim[a] = 0;
          end
        end
        OP_CALIBRATE: begin
          for (int a = 0; a < AXES; a++) begin
            if (s[a] < low_lim[a]) low_lim[a] = s[a];
            if (s[a] > high_lim[a]) high_lim[a] = s[a];
          end
        end
        OP_MEASURE: begin
          lv.x = rescale(s[0], low_lim[0], high_lim[0]);
          lv.y = rescale(s[1], low_lim[1], high_lim[1]);
          lv.z = rescale(s[2], low_lim[2], high_lim[2]);
          pending_levels.push_back(lv);
        end
        default: ;
      endcase
    endfunction

    // Compares one result word with the oldest predicted levels.
    function void check_levels(logic [23:0] word);
      levels_t got;
      levels_t want;
      got = word[3*LEVEL_W-1:0];
      if (pending_levels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result word: x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        return;
      end
      want = pending_levels.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Level mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                   want.x, want.y, want.z, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // sample_x[12:0], sample_y[25:13], sample_z[38:26]
  logic [1:0]  in_tuser = '0;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // level_x[6:0], level_y[13:7], level_z[20:14]

  calib_scoreboard sb = new();
  bit idle_free = 1'b0;
  bit hold_req = 1'b0;

  accel_minmax_calibrate_rescale u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Offers one word, with an occasional idle gap first, and waits for it to go in.
  task automatic send_word(input logic [1:0] op, input sample_t sx, input sample_t sy,
                           input sample_t sz);
    int gap;
    if (!idle_free && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, sz, sy, sx};
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, sx, sy, sz);
  endtask

  // Mostly full-range samples, with zero, the extremes and a narrow band near zero.
  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 12) return sample_t'(-4096);
    if (r < 16) return sample_t'(4095);
    if (r < 40) return sample_t'($urandom_range(0, 200) - 100);
    return sample_t'($urandom_range(0, 8191));
  endfunction

  // Result side: checks accepted words and decides readiness for the next edge.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_levels(out_tdata);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!idle_free && $urandom_range(0, 99) < 20) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corner words, then a long random run.
  initial begin
    int      sent;
    int      r;
    logic [1:0] op;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits, samples at and beyond them.
    send_word(OP_MEASURE, 0, 0, 0);
    send_word(OP_MEASURE, -4096, 4095, -4000);
    send_word(OP_MEASURE, 4000, 3999, -1);
    // Widen to the full sample range on some axes.
    send_word(OP_CALIBRATE, -4096, 4095, 0);
    send_word(OP_CALIBRATE, 4095, -4096, 1234);
    send_word(OP_MEASURE, -4096, 4095, 1234);
    send_word(OP_MEASURE, 4095, -4096, 0);
    // The unused opcode must leave the limits alone.
    send_word(OP_UNUSED, 123, -7, 4095);
    send_word(OP_MEASURE, 100, -100, 0);
    // After a clear every axis has an empty range.
    send_word(OP_CLEAR, -4096, 4095, 17);
    send_word(OP_MEASURE, 0, 4095, -4096);
    // One axis stays empty, the others get narrow ranges on either side of zero.
    send_word(OP_CALIBRATE, 0, 50, -50);
    send_word(OP_MEASURE, 0, 25, -25);
    send_word(OP_MEASURE, -1, 51, 1);
    send_word(OP_MEASURE, -4096, -4096, 4095);
    send_word(OP_CALIBRATE, 1, 1, 1);
    send_word(OP_MEASURE, 1, 0, 0);
    send_word(OP_UNUSED, -4096, -4096, -4096);
    send_word(OP_CLEAR, 0, 0, 0);
    send_word(OP_CALIBRATE, -4096, -4096, -4096);
    send_word(OP_CALIBRATE, 4095, 4095, 4095);
    send_word(OP_MEASURE, -1, 0, 4095);

    // Random run; ignored words do not count towards its length.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent == 100) hold_req = 1'b1;
      idle_free = (sent >= 250 && sent < 370);
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_CLEAR;
      else if (r < 35) op = OP_CALIBRATE;
      else if (r < 95) op = OP_MEASURE;
      else op = OP_UNUSED;
      send_word(op, pick_sample(), pick_sample(), pick_sample());
      if (op != OP_UNUSED) sent++;
    end
    idle_free = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending_levels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/amcr_pkg.sv
hw/rtl/amcr_ctrl.sv
hw/rtl/amcr_dp.sv
hw/rtl/accel_minmax_calibrate_rescale.sv
verif/tb.sv
